// File: rtl/core/ecpd_pkg.sv
package ecpd_pkg;

    // Default sensor side length in pixels.
    localparam int SENSOR_SIDE_DEF = 128;

    // Command kinds.
    localparam logic [1:0] KIND_EVENT = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Packet formats.
    localparam logic [2:0] FMT_NONE = 3'd0;
    localparam logic [2:0] FMT_VAR  = 3'd1;
    localparam logic [2:0] FMT_T16  = 3'd2;
    localparam logic [2:0] FMT_T24  = 3'd3;
    localparam logic [2:0] FMT_T32  = 3'd4;

    // Register indexes.
    localparam logic REG_EVENT_FORMAT = 1'b0;

    // Error code bits.
    localparam int ERR_SYNC_BIT = 0;
    localparam int ERR_BACK_BIT = 1;

    // Decoded event packet.
    typedef struct packed {
        logic        valid;
        logic        backward;
        logic [1:0]  err;
        logic [2:0]  len;
        logic [6:0]  x;
        logic [6:0]  y;
        logic        pol;
        logic [31:0] t;
    } t_dec;

endpackage

// File: rtl/core/ecpd_decode.sv
module ecpd_decode
    import ecpd_pkg::*;
(
    input  logic [2:0]  i_format,
    input  logic [7:0]  i_byte0,
    input  logic [7:0]  i_byte1,
    input  logic [7:0]  i_byte2,
    input  logic [7:0]  i_byte3,
    input  logic [7:0]  i_byte4,
    input  logic [7:0]  i_byte5,
    input  logic [31:0] i_last_time,
    output t_dec        o_dec
);

    logic [2:0]  fmt;
    logic        sync;
    logic [31:0] t;
    logic [2:0]  len;
    logic        backward;
    logic        valid;

    always_comb begin
        fmt      = (i_format > FMT_T32) ? FMT_T32 : i_format;
        sync     = i_byte0[7];
        t        = '0;
        len      = 3'd2;
        case (fmt)
            FMT_NONE: begin
                t   = '0;
                len = 3'd2;
            end
            FMT_VAR: begin
                // Chunks of seven bits, most significant first; bit 7 ends the run.
                if (i_byte2[7]) begin
                    t   = {25'd0, i_byte2[6:0]};
                    len = 3'd3;
                end else if (i_byte3[7]) begin
                    t   = {18'd0, i_byte2[6:0], i_byte3[6:0]};
                    len = 3'd4;
                end else if (i_byte4[7]) begin
                    t   = {11'd0, i_byte2[6:0], i_byte3[6:0], i_byte4[6:0]};
                    len = 3'd5;
                end else begin
                    t    = {4'd0, i_byte2[6:0], i_byte3[6:0], i_byte4[6:0], i_byte5[6:0]};
                    len  = 3'd6;
                    sync = i_byte0[7] & i_byte5[7];
                end
            end
            FMT_T16: begin
                t   = {16'd0, i_byte2, i_byte3};
                len = 3'd4;
            end
            FMT_T24: begin
                t   = {8'd0, i_byte2, i_byte3, i_byte4};
                len = 3'd5;
            end
            default: begin
                t   = {i_byte2, i_byte3, i_byte4, i_byte5};
                len = 3'd6;
            end
        endcase
        backward = (fmt != FMT_NONE) && (t < i_last_time);
        valid    = sync && !backward;

        o_dec.valid    = valid;
        o_dec.backward = backward;
        o_dec.err      = '0;
        o_dec.err[ERR_SYNC_BIT] = !sync;
        o_dec.err[ERR_BACK_BIT] = backward;
        o_dec.len      = valid ? len : len + 3'd1;
        o_dec.x        = i_byte1[6:0];
        o_dec.y        = i_byte0[6:0];
        o_dec.pol      = i_byte1[7];
        o_dec.t        = t;
    end

endmodule

// File: rtl/core/event_camera_packet_decoder.sv
// Event-camera packet decoder with a signed time surface. Each transfer on the
// input channel carries one command: an event packet (kind 0), a pixel read
// (kind 1) or a clear of the first-time latch (kind 2); every command yields
// exactly one result transfer. The block takes one command per clock cycle
// while the result channel does not stall, through two registers (input
// register, then result register); the time surface memory takes one write
// and one registered read per cycle. After reset the block runs a clearing
// pass over all SENSOR_SIDE*SENSOR_SIDE time surface entries, one per cycle
// (16384 at the default size), and holds o_in_stall high until it is done;
// configuration writes are taken during that pass as at any other time. The
// packet format register lives at byte address 0 of the APB-style port and
// should only be changed while no commands are in flight.
module event_camera_packet_decoder
    import ecpd_pkg::*;
#(
    parameter int SENSOR_SIDE = SENSOR_SIDE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    // Command channel.
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_kind,
    input  logic [7:0]         i_byte0,
    input  logic [7:0]         i_byte1,
    input  logic [7:0]         i_byte2,
    input  logic [7:0]         i_byte3,
    input  logic [7:0]         i_byte4,
    input  logic [7:0]         i_byte5,
    input  logic [6:0]         i_read_x,
    input  logic [6:0]         i_read_y,

    // Result channel.
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_event_valid,
    output logic [1:0]         o_error_code,
    output logic [2:0]         o_bytes_consumed,
    output logic [6:0]         o_ev_x,
    output logic [6:0]         o_ev_y,
    output logic               o_ev_polarity,
    output logic [31:0]        o_ev_time,
    output logic signed [32:0] o_pixel_value,
    output logic [31:0]        o_first_time
);

    localparam int DEPTH = SENSOR_SIDE * SENSOR_SIDE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [7:0] SIDE8 = 8'(SENSOR_SIDE);
    localparam logic [13:0] SIDE14 = 14'(SENSOR_SIDE);

    // Configuration register. Only bit 2 of the address is decoded: register 0
    // answers whenever it is clear, and a set bit selects beyond the register list.
    logic [2:0] r_event_format;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_event_format <= FMT_T32;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_EVENT_FORMAT)) begin
            r_event_format <= pwdata[2:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_EVENT_FORMAT) ? {29'd0, r_event_format} : 32'd0;

    // Clearing pass over the time surface after reset.
    logic          r_clr_done;
    logic [AW-1:0] r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_done <= 1'b0;
            r_clr_cnt  <= '0;
        end else if (!r_clr_done) begin
            r_clr_cnt <= r_clr_cnt + AW'(1);
            if (r_clr_cnt == AW'(DEPTH - 1)) begin
                r_clr_done <= 1'b1;
            end
        end
    end

    // Input register stage.
    logic       r_s1_v;
    logic [1:0] r_s1_kind;
    logic [7:0] r_s1_b0, r_s1_b1, r_s1_b2, r_s1_b3, r_s1_b4, r_s1_b5;
    logic [6:0] r_s1_rx, r_s1_ry;

    logic       r_s2_v;
    logic       s1_adv;
    logic       in_accept;

    // The first stage moves on whenever the result register is free or is
    // being emptied in this cycle, so a new transfer can come in every cycle.
    assign s1_adv     = r_s1_v && (!r_s2_v || !i_out_stall);
    assign o_in_stall = !r_clr_done || (r_s1_v && !s1_adv);
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (in_accept) begin
            r_s1_v <= 1'b1;
        end else if (s1_adv) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_kind <= i_kind;
            r_s1_b0   <= i_byte0;
            r_s1_b1   <= i_byte1;
            r_s1_b2   <= i_byte2;
            r_s1_b3   <= i_byte3;
            r_s1_b4   <= i_byte4;
            r_s1_b5   <= i_byte5;
            r_s1_rx   <= i_read_x;
            r_s1_ry   <= i_read_y;
        end
    end

    // Packet decode and checks against the running time.
    logic [31:0] r_last_time;
    logic [31:0] r_first_latch;
    t_dec        dec;

    ecpd_decode u_decode (
        .i_format    (r_event_format),
        .i_byte0     (r_s1_b0),
        .i_byte1     (r_s1_b1),
        .i_byte2     (r_s1_b2),
        .i_byte3     (r_s1_b3),
        .i_byte4     (r_s1_b4),
        .i_byte5     (r_s1_b5),
        .i_last_time (r_last_time),
        .o_dec       (dec)
    );

    logic        is_event;
    logic        is_read;
    logic        ev_ok;
    logic        ev_in_range;
    logic        rd_in_range;
    logic [13:0] ev_addr14;
    logic [13:0] rd_addr14;
    logic [31:0] n_last_time;
    logic [31:0] n_first_latch;

    assign is_event    = (r_s1_kind == KIND_EVENT);
    assign is_read     = (r_s1_kind == KIND_READ);
    assign ev_ok       = is_event && dec.valid;
    assign ev_in_range = ({1'b0, dec.x} < SIDE8) && ({1'b0, dec.y} < SIDE8);
    assign rd_in_range = ({1'b0, r_s1_rx} < SIDE8) && ({1'b0, r_s1_ry} < SIDE8);
    assign ev_addr14   = {7'd0, dec.x} * SIDE14 + {7'd0, dec.y};
    assign rd_addr14   = {7'd0, r_s1_rx} * SIDE14 + {7'd0, r_s1_ry};

    always_comb begin
        n_last_time   = r_last_time;
        n_first_latch = r_first_latch;
        case (r_s1_kind)
            KIND_EVENT: begin
                if (dec.valid) begin
                    n_last_time = dec.t;
                    if (r_first_latch == 32'd0) begin
                        n_first_latch = dec.t;
                    end
                end else if (dec.backward) begin
                    // A step back in time restarts the running time at zero.
                    n_last_time = 32'd0;
                end
            end
            KIND_CLEAR: begin
                n_first_latch = 32'd0;
            end
            default: begin
                n_last_time   = r_last_time;
                n_first_latch = r_first_latch;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time   <= '0;
            r_first_latch <= '0;
        end else if (s1_adv) begin
            r_last_time   <= n_last_time;
            r_first_latch <= n_first_latch;
        end
    end

    // Time surface memory. An entry holds the timestamp, negated for off
    // polarity. The read of a pixel command and the write of an event packet
    // never come from the same transfer, so no forwarding is needed.
    logic        [32:0] r_mem [DEPTH];
    logic signed [32:0] r_rd;
    logic               mem_we;
    logic        [AW-1:0] mem_waddr;
    logic        [32:0] mem_wdata;
    logic        [32:0] ev_value;

    assign ev_value  = dec.pol ? {1'b0, dec.t} : (33'd0 - {1'b0, dec.t});
    assign mem_we    = !r_clr_done || (s1_adv && ev_ok && ev_in_range);
    assign mem_waddr = r_clr_done ? AW'(ev_addr14) : r_clr_cnt;
    assign mem_wdata = r_clr_done ? ev_value : 33'd0;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (s1_adv) begin
            r_rd <= r_mem[AW'(rd_addr14)];
        end
    end

    // Result register.
    logic        r_s2_ev;
    logic        r_s2_rd_ok;
    t_dec        r_s2_dec;
    logic [31:0] r_s2_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s1_adv) begin
            r_s2_v <= 1'b1;
        end else if (!i_out_stall) begin
            r_s2_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_ev    <= is_event;
            r_s2_rd_ok <= is_read && rd_in_range;
            r_s2_dec   <= dec;
            r_s2_first <= n_first_latch;
        end
    end

    // Fields that do not belong to the command kind read as zero.
    assign o_out_valid      = r_s2_v;
    assign o_event_valid    = r_s2_ev && r_s2_dec.valid;
    assign o_error_code     = r_s2_ev ? r_s2_dec.err : 2'd0;
    assign o_bytes_consumed = r_s2_ev ? r_s2_dec.len : 3'd0;
    assign o_ev_x           = r_s2_ev ? r_s2_dec.x : 7'd0;
    assign o_ev_y           = r_s2_ev ? r_s2_dec.y : 7'd0;
    assign o_ev_polarity    = r_s2_ev && r_s2_dec.pol;
    assign o_ev_time        = r_s2_ev ? r_s2_dec.t : 32'd0;
    assign o_pixel_value    = r_s2_rd_ok ? r_rd : 33'sd0;
    assign o_first_time     = r_s2_first;

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import ecpd_pkg::*;

    // Kind 3 is outside the documented set; the decoder must ignore it and
    // still return a result carrying only the first-time latch.
    localparam logic [1:0] KIND_SPARE = 2'd3;

    // Format register values above the 32-bit format, which the decoder
    // must treat as the 32-bit format.
    localparam logic [2:0] FMT_ALIAS_LO = 3'd5;
    localparam logic [2:0] FMT_ALIAS_MID = 3'd6;
    localparam logic [2:0] FMT_ALIAS_HI = 3'd7;

    // The format register is register 0 and sits at byte address 0.
    localparam logic [2:0] FORMAT_ADDR = {REG_EVENT_FORMAT, 2'b00};

    localparam int IDLE_PCT = 31;
    localparam int ITEMS_PER_FORMAT = 70;
    localparam int HOLD_CYCLES = 250;
    // The clearing pass after reset keeps the input stalled while it covers all
    // 16384 entries; the watchdog limit leaves room for that several times over.
    localparam int STUCK_LIMIT = 60000;
    // The pipeline is two registers deep, so the settle wait covers any work
    // still in flight once the last result has come out.
    localparam int SETTLE_CYCLES = 8;

    // One command as seen on the input channel.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic [7:0] byte4;
        logic [7:0] byte5;
        logic [6:0] read_x;
        logic [6:0] read_y;
    } packet_cmd_t;

    // One result as seen on the output channel.
    typedef struct packed {
        logic               ev_valid;
        logic [1:0]         err;
        logic [2:0]         len;
        logic [6:0]         x;
        logic [6:0]         y;
        logic               pol;
        logic [31:0]        t;
        logic signed [32:0] pix;
        logic [31:0]        first;
    } decode_result_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_kind;
    logic [7:0]         i_byte0;
    logic [7:0]         i_byte1;
    logic [7:0]         i_byte2;
    logic [7:0]         i_byte3;
    logic [7:0]         i_byte4;
    logic [7:0]         i_byte5;
    logic [6:0]         i_read_x;
    logic [6:0]         i_read_y;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_event_valid;
    logic [1:0]         o_error_code;
    logic [2:0]         o_bytes_consumed;
    logic [6:0]         o_ev_x;
    logic [6:0]         o_ev_y;
    logic               o_ev_polarity;
    logic [31:0]        o_ev_time;
    logic signed [32:0] o_pixel_value;
    logic [31:0]        o_first_time;

    // Our own copy of the decoder state, advanced at every accepted command.
    logic [2:0]         format_setting;
    logic [31:0]        prev_stamp;
    logic [31:0]        first_stamp;
    logic signed [32:0] surface_copy [0:16383];

    // Results still owed by the block, oldest first.
    decode_result_t     pending_results [$];
    decode_result_t     oldest_expected;
    // Surface addresses written lately, so that random reads mostly land on
    // entries that hold something.
    logic [13:0]        written_pixels [$];

    int  mismatch_count = 0;
    int  stuck_cycles;
    int  stall_hold_req = 0;
    int  hold_left = 0;
    bit  send_gaps = 1'b1;
    bit  recv_stalls = 1'b1;

    event_camera_packet_decoder dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Works out what the block must return for one command and moves the
    // state copy on. Format 1 builds the stamp from 7-bit chunks, most
    // significant first, and a chunk with bit 7 set closes the stamp.
    function automatic decode_result_t decode_command(packet_cmd_t c);
        decode_result_t   r;
        logic [2:0]       fmt;
        logic [31:0]      t;
        logic [3:0][7:0]  tsb;
        logic             sync;
        logic             backward;
        logic             closed;
        logic [2:0]       len;
        r = '0;
        tsb = {c.byte2, c.byte3, c.byte4, c.byte5};
        case (c.kind)
            KIND_EVENT: begin
                fmt = (format_setting > FMT_T32) ? FMT_T32 : format_setting;
                sync = c.byte0[7];
                t = '0;
                len = 3'd2;
                closed = 1'b0;
                case (fmt)
                    FMT_VAR: begin
                        for (int k = 3; k >= 0; k--) begin
                            if (!closed) begin
                                t = {t[24:0], tsb[k][6:0]};
                                closed = tsb[k][7];
                                len++;
                            end
                        end
                        // A stamp that never closes counts as a lost sync.
                        sync = sync && closed;
                    end
                    FMT_T16: begin
                        t = {16'd0, tsb[3:2]};
                        len = 3'd4;
                    end
                    FMT_T24: begin
                        t = {8'd0, tsb[3:1]};
                        len = 3'd5;
                    end
                    FMT_T32: begin
                        t = tsb;
                        len = 3'd6;
                    end
                    default: ;
                endcase
                backward = (fmt != FMT_NONE) && (t < prev_stamp);
                r.ev_valid = sync && !backward;
                if (r.ev_valid) begin
                    if (first_stamp == '0) first_stamp = t;
                    // Off events are stored as the negated stamp.
                    surface_copy[{c.byte1[6:0], c.byte0[6:0]}] =
                        c.byte1[7] ? {1'b0, t} : 33'd0 - {1'b0, t};
                    written_pixels = {written_pixels, {c.byte1[6:0], c.byte0[6:0]}};
                    if (written_pixels.size() > 64) void'(written_pixels.pop_front());
                    prev_stamp = t;
                end else begin
                    // A step back restarts the time check, even without sync.
                    if (backward) prev_stamp = '0;
                    len++;
                end
                r.err[ERR_SYNC_BIT] = !sync;
                r.err[ERR_BACK_BIT] = backward;
                r.len = len;
                r.x = c.byte1[6:0];
                r.y = c.byte0[6:0];
                r.pol = c.byte1[7];
                r.t = t;
            end
            KIND_READ: r.pix = surface_copy[{c.read_x, c.read_y}];
            KIND_CLEAR: first_stamp = '0;
            default: ;
        endcase
        r.first = first_stamp;
        return r;
    endfunction

    function automatic packet_cmd_t event_cmd(input logic sync, input logic pol,
                                              input logic [6:0] x, input logic [6:0] y,
                                              input logic [31:0] stamp_bytes);
        packet_cmd_t c;
        c = '0;
        c.kind = KIND_EVENT;
        c.byte0 = {sync, y};
        c.byte1 = {pol, x};
        {c.byte2, c.byte3, c.byte4, c.byte5} = stamp_bytes;
        return c;
    endfunction

    function automatic packet_cmd_t plain_cmd(input logic [1:0] kind,
                                              input logic [6:0] x, input logic [6:0] y);
        packet_cmd_t c;
        c = '0;
        c.kind = kind;
        c.read_x = x;
        c.read_y = y;
        return c;
    endfunction

    // Mostly well-formed packets whose stamps climb from the last accepted
    // one, so that events keep passing the time check; the rest is raw noise,
    // pixel reads, latch clears and the unused kind.
    function automatic packet_cmd_t random_command();
        packet_cmd_t      c;
        logic [2:0]       fmt;
        logic [31:0]      t;
        logic [3:0][7:0]  tsb;
        int               roll;
        int               n;
        c = {$urandom, $urandom};
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
            c.kind = KIND_EVENT;
            if (roll < 66) begin
                fmt = (format_setting > FMT_T32) ? FMT_T32 : format_setting;
                c.byte0[7] = ($urandom_range(0, 19) != 0);
                case ($urandom_range(0, 9))
                    0: t = $urandom;
                    1: t = prev_stamp - $urandom_range(1, 50);
                    default: t = prev_stamp + $urandom_range(0, 300);
                endcase
                tsb = {c.byte2, c.byte3, c.byte4, c.byte5};
                case (fmt)
                    FMT_VAR: begin
                        t = t & 32'h0FFF_FFFF;
                        n = 1;
                        while (n < 4 && (t >> (7 * n)) != 0) n++;
                        // Sometimes lead with a zero chunk.
                        if (n < 4 && $urandom_range(0, 3) == 0) n++;
                        for (int k = 0; k < n; k++) begin
                            tsb[3 - k] = {k == n - 1, 7'(t >> (7 * (n - 1 - k)))};
                        end
                    end
                    FMT_T16: tsb[3:2] = t[15:0];
                    FMT_T24: tsb[3:1] = t[23:0];
                    FMT_T32: tsb = t;
                    default: ;
                endcase
                {c.byte2, c.byte3, c.byte4, c.byte5} = tsb;
            end
        end else if (roll < 90) begin
            c.kind = KIND_READ;
            if (written_pixels.size() != 0 && $urandom_range(0, 3) != 0) begin
                {c.read_x, c.read_y} =
                    written_pixels[$urandom_range(0, written_pixels.size() - 1)];
            end
        end else if (roll < 97) begin
            c.kind = KIND_CLEAR;
        end else begin
            c.kind = KIND_SPARE;
        end
        return c;
    endfunction

    // Offers one command, with random idle cycles in front of it when gaps
    // are enabled. Valid is left high afterward so that back-to-back
    // transfers need no extra cycle; whoever stops sending lowers it.
    task automatic send_command(input packet_cmd_t c);
        if (send_gaps) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        {i_kind, i_byte0, i_byte1, i_byte2, i_byte3, i_byte4, i_byte5,
         i_read_x, i_read_y} <= c;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pending_results = {pending_results, decode_command(c)};
    endtask

    task automatic send_random(input int count);
        repeat (count) send_command(random_command());
    endtask

    // Stops sending and waits until every owed result has come out, then
    // lets the pipeline settle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One APB transfer: a setup phase, then an access phase held until
    // pready. Waiting on the clock first keeps psel from being lowered and raised in
    // the same step when two transfers follow each other.
    task automatic apb_transfer(input logic wr, input logic [31:0] wdata,
                                output logic [31:0] rdata);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= FORMAT_ADDR;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic set_format(input logic [2:0] fmt);
        logic [31:0] readback;
        drain_results();
        apb_transfer(1'b1, {29'd0, fmt}, readback);
        format_setting = fmt;
        apb_transfer(1'b0, '0, readback);
        compare_field("event_format", 64'(fmt), 64'(readback[2:0]));
    endtask

    // Each result transfer is checked against the oldest owed result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no command waiting for it");
                mismatch_count++;
            end else begin
                oldest_expected = pending_results.pop_front();
                compare_field("event_valid", 64'(oldest_expected.ev_valid),
                              64'(o_event_valid));
                compare_field("error_code", 64'(oldest_expected.err), 64'(o_error_code));
                compare_field("bytes_consumed", 64'(oldest_expected.len),
                              64'(o_bytes_consumed));
                compare_field("ev_x", 64'(oldest_expected.x), 64'(o_ev_x));
                compare_field("ev_y", 64'(oldest_expected.y), 64'(o_ev_y));
                compare_field("ev_polarity", 64'(oldest_expected.pol), 64'(o_ev_polarity));
                compare_field("ev_time", 64'(oldest_expected.t), 64'(o_ev_time));
                compare_field("pixel_value", {31'd0, oldest_expected.pix},
                              {31'd0, o_pixel_value});
                compare_field("first_time", 64'(oldest_expected.first), 64'(o_first_time));
            end
        end
    end

    // The receiving side. It stalls at random, stops stalling during the
    // steady stretch, and on request holds off without a break so that the block
    // backs up into its input.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_hold_req != 0) begin
                hold_left = stall_hold_req;
                stall_hold_req = 0;
            end
            if (hold_left != 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (!recv_stalls) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // Ends the run if neither channel moves for too long.
    initial begin
        stuck_cycles = 0;
        while (stuck_cycles < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && i_out_stall === 1'b0)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    // Reset value of the format register, then the 32-bit format: reads of
    // a cleared entry, an off event and its negative entry, a step back in
    // time, a lost sync, the largest stamp at the far corner, the latch
    // clear, the unused kind and a packet that is both unsynced and late.
    task automatic test_reset_defaults();
        logic [31:0] readback;
        apb_transfer(1'b0, '0, readback);
        compare_field("event_format", 64'(FMT_T32), 64'(readback[2:0]));
        format_setting = FMT_T32;
        send_command(plain_cmd(KIND_READ, 7'd0, 7'd0));
        send_command(event_cmd(1'b1, 1'b0, 7'd0, 7'd0, 32'h0000_0010));
        send_command(plain_cmd(KIND_READ, 7'd0, 7'd0));
        send_command(event_cmd(1'b1, 1'b1, 7'd5, 7'd9, 32'h0000_0005));
        send_command(event_cmd(1'b0, 1'b1, 7'd127, 7'd127, 32'hFFFF_FFFF));
        send_command(event_cmd(1'b1, 1'b1, 7'd127, 7'd127, 32'hFFFF_FFFF));
        send_command(plain_cmd(KIND_READ, 7'd127, 7'd127));
        send_command(plain_cmd(KIND_CLEAR, 7'd0, 7'd0));
        send_command(plain_cmd(KIND_SPARE, 7'd127, 7'd127));
        send_command(event_cmd(1'b0, 1'b0, 7'd1, 7'd2, 32'h0000_0000));
        send_command(event_cmd(1'b1, 1'b0, 7'd3, 7'd4, 32'h0000_0000));
    endtask

    // Without a stamp the time check never fires and a good event zeroes
    // the running time.
    task automatic test_no_timestamp();
        set_format(FMT_NONE);
        send_command(event_cmd(1'b1, 1'b1, 7'd64, 7'd33, 32'hA5A5_5A5A));
        send_command(event_cmd(1'b0, 1'b0, 7'd10, 7'd20, 32'h0000_0000));
    endtask

    // Variable stamps: one chunk, four chunks, a stamp that never closes,
    // and a closed stamp that lands behind the running time.
    task automatic test_variable_timestamp();
        set_format(FMT_VAR);
        send_command(event_cmd(1'b1, 1'b1, 7'd2, 7'd3, 32'hFF00_0000));
        send_command(event_cmd(1'b1, 1'b0, 7'd4, 7'd5, 32'h0102_0384));
        send_command(event_cmd(1'b1, 1'b1, 7'd6, 7'd7, 32'h7F7F_7F7F));
        send_command(event_cmd(1'b1, 1'b1, 7'd8, 7'd9, 32'h8100_0000));
    endtask

    // 16- and 24-bit stamps at their largest, and a step back on the switch.
    task automatic test_short_timestamps();
        set_format(FMT_T16);
        send_command(event_cmd(1'b1, 1'b1, 7'd11, 7'd12, 32'hFFFF_0000));
        set_format(FMT_T24);
        send_command(event_cmd(1'b1, 1'b1, 7'd13, 7'd14, 32'h0000_0100));
        send_command(event_cmd(1'b1, 1'b0, 7'd15, 7'd16, 32'hFFFF_FF00));
    endtask

    // The largest register value must decode as the 32-bit format.
    task automatic test_out_of_range_format();
        set_format(FMT_ALIAS_HI);
        send_command(event_cmd(1'b1, 1'b0, 7'd100, 7'd50, 32'h0100_0000));
        send_command(plain_cmd(KIND_READ, 7'd100, 7'd50));
    endtask

    task automatic test_random_traffic();
        logic [2:0] settings [8];
        settings = '{FMT_T32, FMT_NONE, FMT_VAR, FMT_T16, FMT_T24,
                     FMT_ALIAS_LO, FMT_VAR, FMT_ALIAS_MID};
        foreach (settings[i]) begin
            set_format(settings[i]);
            send_random(ITEMS_PER_FORMAT);
        end
    endtask

    // Full rate on both sides for a long stretch.
    task automatic test_steady_stream();
        set_format(FMT_T32);
        send_gaps = 1'b0;
        recv_stalls = 1'b0;
        send_random(120);
        send_gaps = 1'b1;
        recv_stalls = 1'b1;
    endtask

    // The receiver holds off while the sender keeps offering, so the block
    // fills and stalls its input; then the sender pauses until everything
    // has come out and resumes.
    task automatic test_back_pressure();
        set_format(FMT_VAR);
        send_gaps = 1'b0;
        stall_hold_req = HOLD_CYCLES;
        send_random(40);
        send_gaps = 1'b1;
        drain_results();
        send_random(20);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        {i_kind, i_byte0, i_byte1, i_byte2, i_byte3, i_byte4, i_byte5,
         i_read_x, i_read_y} = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        format_setting = FMT_T32;
        prev_stamp = '0;
        first_stamp = '0;
        foreach (surface_copy[i]) surface_copy[i] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_no_timestamp();
        test_variable_timestamp();
        test_short_timestamps();
        test_out_of_range_format();
        test_random_traffic();
        test_steady_stream();
        test_back_pressure();

        // Once everything owed has arrived, the settle wait catches any stray
        // result transfer.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/ecpd_pkg.sv
rtl/core/ecpd_decode.sv
rtl/core/event_camera_packet_decoder.sv
sim/tb.sv
